FILE: src/pckey_pkg.sv
`timescale 1ns / 1ps

package pckey_pkg;

  localparam int unsigned NUM_CLASSES  = 12;
  localparam int unsigned HALF_CLASSES = NUM_CLASSES / 2;
  localparam int unsigned NUM_MODES    = 6;
  localparam int unsigned PITCH_W      = 7;
  localparam int unsigned ROOT_W       = 4;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned SCORE_W      = 17;
  localparam int unsigned TSUM_W       = 17;
  localparam int unsigned COST_W       = 5;
  localparam int unsigned TENSION_FULL = 18;
  localparam int unsigned FRAC_BITS    = 16;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam logic [ROOT_W-1:0] LAST_ROOT  = 4'd11;
  localparam logic [MODE_W-1:0] LAST_MODE  = 3'd5;
  localparam logic [ROOT_W-1:0] LAST_CLASS = 4'd11;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH,
    B_TENSION,
    B_SDIV_GO,
    B_SDIV_WAIT,
    B_TDIV_GO,
    B_TDIV_WAIT,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Pitch class by conditional subtraction of 96, 48, 24 and 12.
  function automatic logic [ROOT_W-1:0] pitch_class(input logic [PITCH_W-1:0] pitch);
    logic [PITCH_W-1:0] r;
    r = pitch;
    if (r >= 7'd96) r = r - 7'd96;
    if (r >= 7'd48) r = r - 7'd48;
    if (r >= 7'd24) r = r - 7'd24;
    if (r >= 7'd12) r = r - 7'd12;
    return r[ROOT_W-1:0];
  endfunction

  // Scale membership masks rooted at pitch class zero.
  function automatic logic [NUM_CLASSES-1:0] mode_mask(input logic [MODE_W-1:0] mode);
    logic [NUM_CLASSES-1:0] m;
    case (mode)
      3'd0:    m = 12'hAB5;
      3'd1:    m = 12'h5AD;
      3'd2:    m = 12'h6AD;
      3'd3:    m = 12'h6B5;
      3'd4:    m = 12'h5AB;
      3'd5:    m = 12'hAD5;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Mask rotated up by the root.
  function automatic logic [NUM_CLASSES-1:0] tmpl_mask(input logic [ROOT_W-1:0] root,
                                                       input logic [MODE_W-1:0] mode);
    logic [2*NUM_CLASSES-1:0] twice;
    twice = {mode_mask(mode), mode_mask(mode)} << root;
    return twice[2*NUM_CLASSES-1:NUM_CLASSES];
  endfunction

  // Weight times folded distance between a class and the root.
  function automatic logic [COST_W-1:0] dist_cost(input logic [ROOT_W-1:0] pc,
                                                  input logic [ROOT_W-1:0] root);
    logic [ROOT_W-1:0] diff;
    logic [ROOT_W-1:0] d;
    logic [COST_W-1:0] c;
    diff = (pc >= root) ? pc - root : pc + 4'd12 - root;
    d    = (diff > 4'd6) ? 4'd12 - diff : diff;
    case (d)
      4'd0:    c = 5'd0;
      4'd1:    c = 5'd3;
      4'd2:    c = 5'd4;
      4'd3:    c = 5'd9;
      4'd4:    c = 5'd4;
      4'd5:    c = 5'd5;
      4'd6:    c = 5'd18;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/pckey_front.sv
`timescale 1ns / 1ps

module pckey_front #(
  parameter int unsigned MAX_NOTES = 4096,
  parameter int unsigned CW        = 13
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [pckey_pkg::PITCH_W-1:0]                   pitch_i,
  input  logic                                            last_i,
  input  pckey_pkg::q_status_t                            q_status_i,
  output logic                                            push_o,
  output logic [pckey_pkg::NUM_CLASSES-1:0][CW-1:0]       push_bins_o,
  output logic [CW-1:0]                                   push_n_o
);
  import pckey_pkg::*;

  logic [NUM_CLASSES-1:0][CW-1:0] hist_q, hist_d;
  logic [CW-1:0]                  seen_q, seen_d;
  logic                           accept;
  logic                           room;
  logic [ROOT_W-1:0]              pc;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign pc         = pitch_class(pitch_i);
  assign room       = seen_q < CW'(MAX_NOTES);

  always_comb begin
    hist_d = hist_q;
    seen_d = seen_q;
    if (accept && room) begin
      hist_d[pc] = hist_q[pc] + CW'(1);
      seen_d     = seen_q + CW'(1);
    end
  end

  // The closing note is included in the pushed set.
  assign push_o      = accept && last_i;
  assign push_bins_o = hist_d;
  assign push_n_o    = seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      seen_q <= '0;
    end else if (push_o) begin
      hist_q <= '0;
      seen_q <= '0;
    end else begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end

endmodule

FILE: src/pckey_queue.sv
`timescale 1ns / 1ps

module pckey_queue #(
  parameter int unsigned CW = 13
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      push_i,
  input  logic [pckey_pkg::NUM_CLASSES-1:0][CW-1:0] push_bins_i,
  input  logic [CW-1:0]                             push_n_i,
  input  logic                                      pop_i,
  output pckey_pkg::q_status_t                      status_o,
  output logic [pckey_pkg::NUM_CLASSES-1:0][CW-1:0] head_bins_o,
  output logic [CW-1:0]                             head_n_o
);
  import pckey_pkg::*;

  logic [NUM_CLASSES-1:0][CW-1:0] bins_q [Q_DEPTH];
  logic [CW-1:0]                  n_q    [Q_DEPTH];
  logic [Q_PTR_W-1:0]             wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]             cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bins_q[wr_ptr_q] <= push_bins_i;
      n_q[wr_ptr_q]    <= push_n_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign status_o.full  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign head_bins_o    = bins_q[rd_ptr_q];
  assign head_n_o       = n_q[rd_ptr_q];

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("set queue occupancy beyond its depth");

endmodule

FILE: src/pckey_div.sv
`timescale 1ns / 1ps

module pckey_div #(
  parameter int unsigned DW = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DW-1:0]                   num_i,
  input  logic [DW-1:0]                   den_i,
  output logic                            done_o,
  output logic [pckey_pkg::SCORE_W-1:0]   quot_o
);
  import pckey_pkg::*;

  localparam int unsigned STEP_W = $clog2(SCORE_W);

  logic [DW:0]        rem_q;
  logic [DW-1:0]      den_q;
  logic [SCORE_W-1:0] quot_q;
  logic [STEP_W-1:0]  step_q;
  logic               busy_q, done_q;
  logic [DW:0]        trial;
  logic               take;

  // Numerator never exceeds the denominator, so the first step compares
  // without a shift and every later step is an ordinary restoring step.
  assign trial = (step_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= take ? trial - {1'b0, den_q} : trial;
      quot_q <= {quot_q[SCORE_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == STEP_W'(SCORE_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? '0 : quot_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && den_q != '0) |-> rem_q < {1'b0, den_q})
    else $error("divider remainder not below the divisor");

endmodule

FILE: src/pckey_back.sv
`timescale 1ns / 1ps

module pckey_back #(
  parameter int unsigned CW = 13
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  pckey_pkg::q_status_t                      q_status_i,
  input  logic [pckey_pkg::NUM_CLASSES-1:0][CW-1:0] head_bins_i,
  input  logic [CW-1:0]                             head_n_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [pckey_pkg::ROOT_W-1:0]              key_root_o,
  output logic [pckey_pkg::MODE_W-1:0]              best_mode_o,
  output logic [pckey_pkg::COUNT_W-1:0]             in_scale_count_o,
  output logic [pckey_pkg::COUNT_W-1:0]             note_count_o,
  output logic [pckey_pkg::SCORE_W-1:0]             scale_score_o,
  output logic [pckey_pkg::TSUM_W-1:0]              tension_sum_o,
  output logic [pckey_pkg::SCORE_W-1:0]             tension_score_o,
  output logic [pckey_pkg::ROOT_W-1:0]              distinct_classes_o
);
  import pckey_pkg::*;

  localparam int unsigned TW = CW + 5;

  back_state_e state_q, state_d;

  logic scan_en, tens_init, tens_en, div_start, div_sel_t, sscore_ld, emit, out_free;

  logic [ROOT_W-1:0]      root_q;
  logic [MODE_W-1:0]      mode_q;
  logic [NUM_CLASSES-1:0] mask;
  logic [CW-1:0]          lo_sum, hi_sum, lo_q, hi_q, pair_cnt;
  logic [ROOT_W-1:0]      pair_root_q;
  logic [MODE_W-1:0]      pair_mode_q;
  logic                   pair_vld_q;
  logic [CW-1:0]          best_cnt_q;
  logic [ROOT_W-1:0]      key_root_q;
  logic [MODE_W-1:0]      best_mode_q;

  logic [ROOT_W-1:0]      pc_q;
  logic [CW-1:0]          bin;
  logic [TW-1:0]          term;
  logic [TW-1:0]          tension_q;
  logic [ROOT_W-1:0]      distinct_q;
  logic [TW-1:0]          full;
  logic [TW-1:0]          div_num, div_den;
  logic                   div_done;
  logic [SCORE_W-1:0]     div_quot;
  logic [SCORE_W-1:0]     sscore_q;
  logic                   out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:      if (!q_status_i.empty) state_d = B_SCAN;
      B_SCAN:      if (root_q == LAST_ROOT && mode_q == LAST_MODE) state_d = B_FLUSH;
      B_FLUSH:     state_d = B_TENSION;
      B_TENSION:   if (pc_q == LAST_CLASS) state_d = B_SDIV_GO;
      B_SDIV_GO:   state_d = B_SDIV_WAIT;
      B_SDIV_WAIT: if (div_done) state_d = B_TDIV_GO;
      B_TDIV_GO:   state_d = B_TDIV_WAIT;
      B_TDIV_WAIT: if (div_done) state_d = B_EMIT;
      B_EMIT:      if (out_free) state_d = B_IDLE;
      default:     state_d = B_IDLE;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    scan_en   = 1'b0;
    tens_init = 1'b0;
    tens_en   = 1'b0;
    div_start = 1'b0;
    div_sel_t = 1'b0;
    sscore_ld = 1'b0;
    emit      = 1'b0;
    case (state_q)
      B_SCAN:      scan_en = 1'b1;
      B_FLUSH:     tens_init = 1'b1;
      B_TENSION:   tens_en = 1'b1;
      B_SDIV_GO:   div_start = 1'b1;
      B_SDIV_WAIT: sscore_ld = div_done;
      B_TDIV_GO: begin
        div_start = 1'b1;
        div_sel_t = 1'b1;
      end
      B_EMIT:      emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Template scan: partial sums over both halves of the classes, then compare.
  always_comb begin
    mask   = tmpl_mask(root_q, mode_q);
    lo_sum = '0;
    hi_sum = '0;
    for (int i = 0; i < HALF_CLASSES; i++) begin
      if (mask[i]) lo_sum = lo_sum + head_bins_i[i];
      if (mask[i+HALF_CLASSES]) hi_sum = hi_sum + head_bins_i[i+HALF_CLASSES];
    end
  end

  assign pair_cnt = lo_q + hi_q;

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_sum;
    hi_q        <= hi_sum;
    pair_root_q <= root_q;
    pair_mode_q <= mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      mode_q      <= '0;
      pair_vld_q  <= 1'b0;
      best_cnt_q  <= '0;
      key_root_q  <= '0;
      best_mode_q <= '0;
    end else begin
      pair_vld_q <= scan_en;
      if (state_q == B_IDLE) begin
        root_q      <= '0;
        mode_q      <= '0;
        best_cnt_q  <= '0;
        key_root_q  <= '0;
        best_mode_q <= '0;
      end else begin
        if (scan_en) begin
          if (mode_q == LAST_MODE) begin
            mode_q <= '0;
            root_q <= root_q + 1'b1;
          end else begin
            mode_q <= mode_q + 1'b1;
          end
        end
        // Only a strictly larger count replaces the best, so the first wins.
        if (pair_vld_q && pair_cnt > best_cnt_q) begin
          best_cnt_q  <= pair_cnt;
          key_root_q  <= pair_root_q;
          best_mode_q <= pair_mode_q;
        end
      end
    end
  end

  // Tension and distinct classes, one class per cycle.
  assign bin  = head_bins_i[pc_q];
  assign term = TW'(bin) * TW'(dist_cost(pc_q, key_root_q));

  always_ff @(posedge clk_i) begin
    if (tens_init) begin
      pc_q       <= '0;
      tension_q  <= '0;
      distinct_q <= '0;
    end else if (tens_en) begin
      pc_q       <= pc_q + 1'b1;
      tension_q  <= tension_q + term;
      distinct_q <= distinct_q + {{(ROOT_W-1){1'b0}}, bin != '0};
    end
  end

  assign full    = TW'(head_n_i) * TW'(TENSION_FULL);
  assign div_num = div_sel_t ? ((tension_q < full) ? full - tension_q : '0) : TW'(best_cnt_q);
  assign div_den = div_sel_t ? full : TW'(head_n_i);

  pckey_div #(
    .DW(TW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (sscore_ld) sscore_q <= div_quot;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      key_root_o         <= key_root_q;
      best_mode_o        <= best_mode_q;
      in_scale_count_o   <= COUNT_W'(best_cnt_q);
      note_count_o       <= COUNT_W'(head_n_i);
      scale_score_o      <= sscore_q;
      tension_sum_o      <= TSUM_W'(tension_q);
      tension_score_o    <= div_quot;
      distinct_classes_o <= distinct_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pop_o       = emit;

  a_busy_has_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_IDLE |-> !q_status_i.empty)
    else $error("set processing without a queued set");

  a_best_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_TENSION |-> best_cnt_q <= head_n_i)
    else $error("in-scale count above the note count");

  a_emit_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EMIT |-> (tension_q <= full && distinct_q != '0))
    else $error("tension or distinct count out of range at result");

endmodule

FILE: src/pitch_class_key_analysis_top.sv
// Each accepted note transaction only updates the histogram.
// A note marked last closes the set; with an idle back end its result is offered after the
// 72-pair template scan, a 12-class tension pass and two 17-step divisions. Sets are
// analysed one at a time; two closed sets may queue, and the input stalls only while both
// queue entries are taken.
// Asynchronous active-low reset empties the histogram, the set queue and the result register.
`timescale 1ns / 1ps

module pitch_class_key_analysis_top #(
  parameter int unsigned MAX_NOTES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pckey_pkg::PITCH_W-1:0]      pitch_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pckey_pkg::ROOT_W-1:0]       key_root_o,
  output logic [pckey_pkg::MODE_W-1:0]       best_mode_o,
  output logic [pckey_pkg::COUNT_W-1:0]      in_scale_count_o,
  output logic [pckey_pkg::COUNT_W-1:0]      note_count_o,
  output logic [pckey_pkg::SCORE_W-1:0]      scale_score_o,
  output logic [pckey_pkg::TSUM_W-1:0]       tension_sum_o,
  output logic [pckey_pkg::SCORE_W-1:0]      tension_score_o,
  output logic [pckey_pkg::ROOT_W-1:0]       distinct_classes_o
);
  import pckey_pkg::*;

  // Bin and note counters must hold MAX_NOTES itself.
  localparam int unsigned CW = $clog2(MAX_NOTES + 1);

  q_status_t                      q_status;
  logic                           push, pop;
  logic [NUM_CLASSES-1:0][CW-1:0] push_bins, head_bins;
  logic [CW-1:0]                  push_n, head_n;

  // The front end counts pitch classes and hands each closed set to the queue,
  // so new notes keep flowing while the back end is still analysing, unless the queue is full.
  pckey_front #(
    .MAX_NOTES(MAX_NOTES),
    .CW       (CW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pitch_i    (pitch_i),
    .last_i     (last_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_bins_o(push_bins),
    .push_n_o   (push_n)
  );

  pckey_queue #(
    .CW(CW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_bins_i(push_bins),
    .push_n_i   (push_n),
    .pop_i      (pop),
    .status_o   (q_status),
    .head_bins_o(head_bins),
    .head_n_o   (head_n)
  );

  // The back end reads the set at the head of the queue, finds the best key,
  // scores it, and releases the entry once the result is registered.
  pckey_back #(
    .CW(CW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_status_i        (q_status),
    .head_bins_i       (head_bins),
    .head_n_i          (head_n),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .key_root_o        (key_root_o),
    .best_mode_o       (best_mode_o),
    .in_scale_count_o  (in_scale_count_o),
    .note_count_o      (note_count_o),
    .scale_score_o     (scale_score_o),
    .tension_sum_o     (tension_sum_o),
    .tension_score_o   (tension_score_o),
    .distinct_classes_o(distinct_classes_o)
  );

endmodule

FILE: tb/tb_pitch_class_key_analysis_top.sv
`timescale 1ns / 1ps

// Testbench for the pitch-class key analysis block.
// Notes are sent as valid/ready transactions, grouped into sets that are closed by the
// last flag. A predictor kept in this module mirrors the histogram and note counter, and
// on every closing note it works out the key, the scores and the class count that the block
// should report. Each result transaction is compared field by field with the oldest
// prediction still waiting.
module tb_pitch_class_key_analysis_top;
  import pckey_pkg::*;

  localparam int unsigned NOTE_CAP     = 4096;
  localparam int unsigned STALL_LIMIT  = 5000;  // cycles without any transaction
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLDOFF_LEN  = 600;

  // One predicted result: the key that fits best, and the measures taken against it.
  typedef struct {
    logic [ROOT_W-1:0]  root;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] in_scale;
    logic [COUNT_W-1:0] notes;
    logic [SCORE_W-1:0] scale_score;
    logic [TSUM_W-1:0]  tension_sum;
    logic [SCORE_W-1:0] tension_score;
    logic [ROOT_W-1:0]  distinct;
  } key_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [PITCH_W-1:0]   pitch_i;
  logic                 last_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ROOT_W-1:0]    key_root_o;
  logic [MODE_W-1:0]    best_mode_o;
  logic [COUNT_W-1:0]   in_scale_count_o;
  logic [COUNT_W-1:0]   note_count_o;
  logic [SCORE_W-1:0]   scale_score_o;
  logic [TSUM_W-1:0]    tension_sum_o;
  logic [SCORE_W-1:0]   tension_score_o;
  logic [ROOT_W-1:0]    distinct_classes_o;

  // Predictor state: the class histogram and the number of notes counted so far.
  int unsigned class_counts [NUM_CLASSES];
  int unsigned notes_held;

  key_result_t pending_keys[$];

  int unsigned error_count;
  int unsigned notes_sent;
  int unsigned sets_closed;
  int unsigned keys_checked;
  bit          idle_enable;
  int unsigned holdoff_cycles;

  pitch_class_key_analysis_top #(
    .MAX_NOTES(NOTE_CAP)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pitch_i            (pitch_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .key_root_o         (key_root_o),
    .best_mode_o        (best_mode_o),
    .in_scale_count_o   (in_scale_count_o),
    .note_count_o       (note_count_o),
    .scale_score_o      (scale_score_o),
    .tension_sum_o      (tension_sum_o),
    .tension_score_o    (tension_score_o),
    .distinct_classes_o (distinct_classes_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The scale templates are held as seven hex digits, one per degree above the root.
  function automatic logic [27:0] scale_degrees(input int unsigned mode);
    case (mode)
      0:       return 28'h024579B;
      1:       return 28'h023578A;
      2:       return 28'h023579A;
      3:       return 28'h024579A;
      4:       return 28'h013578A;
      default: return 28'h024679B;
    endcase
  endfunction

  function automatic bit class_in_scale(input int unsigned root, input int unsigned mode,
                                        input int unsigned pc);
    logic [27:0] degs;
    degs = scale_degrees(mode);
    for (int k = 0; k < 7; k++) begin
      if ((root + degs[4*(6-k) +: 4]) % 12 == pc) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Weight of the folded distance times the distance itself.
  function automatic int unsigned tension_cost(input int unsigned pc, input int unsigned root);
    int unsigned d;
    int unsigned w;
    d = (pc + 12 - root) % 12;
    if (d > 6) d = 12 - d;
    case (d)
      1, 3, 6: w = 3;
      2:       w = 2;
      4, 5:    w = 1;
      default: w = 0;
    endcase
    return w * d;
  endfunction

  // Searches all roots and modes over the current histogram and queues the expected result.
  function automatic void analyse_set();
    key_result_t     k;
    int unsigned     best_in;
    int unsigned     key_root;
    int unsigned     best_mode;
    int unsigned     cnt;
    int unsigned     tension;
    int unsigned     distinct;
    longint unsigned full;
    best_in   = 0;
    key_root  = 0;
    best_mode = 0;
    tension   = 0;
    distinct  = 0;
    for (int r = 0; r < 12; r++) begin
      for (int m = 0; m < 6; m++) begin
        cnt = 0;
        for (int pc = 0; pc < 12; pc++)
          if (class_in_scale(r, m, pc)) cnt += class_counts[pc];
        // The first pair always sets the best; later ones only by a strictly larger count.
        if (r == 0 && m == 0) best_in = cnt;
        else if (cnt > best_in) begin
          best_in   = cnt;
          key_root  = r;
          best_mode = m;
        end
      end
    end
    for (int pc = 0; pc < 12; pc++) begin
      tension += class_counts[pc] * tension_cost(pc, key_root);
      if (class_counts[pc] != 0) distinct++;
    end
    k.root          = key_root[ROOT_W-1:0];
    k.mode          = best_mode[MODE_W-1:0];
    k.in_scale      = best_in[COUNT_W-1:0];
    k.notes         = notes_held[COUNT_W-1:0];
    k.tension_sum   = tension[TSUM_W-1:0];
    k.distinct      = distinct[ROOT_W-1:0];
    k.scale_score   = '0;
    k.tension_score = '0;
    if (notes_held != 0) begin
      full          = 18 * longint'(notes_held);
      k.scale_score = SCORE_W'((longint'(best_in) << 16) / notes_held);
      if (tension < full) k.tension_score = SCORE_W'(((full - tension) << 16) / full);
    end
    pending_keys.push_back(k);
  endfunction

  function automatic void absorb_note(input logic [PITCH_W-1:0] pitch, input logic last);
    if (notes_held < NOTE_CAP) begin
      class_counts[pitch % 12]++;
      notes_held++;
    end
    if (last) begin
      analyse_set();
      foreach (class_counts[i]) class_counts[i] = 0;
      notes_held = 0;
      sets_closed++;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Offers one note and waits until the block takes it; a short gap may come first.
  task automatic send_note(input logic [PITCH_W-1:0] pitch, input logic last);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pitch_i    <= pitch;
    last_i     <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_note(pitch, last);
    notes_sent++;
  endtask

  function automatic logic [PITCH_W-1:0] pitch_of_class(input int unsigned pc);
    return PITCH_W'(pc + 12 * $urandom_range(0, (127 - pc) / 12));
  endfunction

  // One set of the given size. Half the sets are drawn from a scale with the odd stray
  // note, a quarter from a pair of classes, the rest plain noise over the whole pitch range.
  task automatic send_random_set(input int unsigned size);
    int unsigned flavour;
    int unsigned root;
    int unsigned mode;
    int unsigned pc_a;
    int unsigned pc_b;
    int unsigned pc;
    logic [27:0] degs;
    logic [PITCH_W-1:0] p;
    flavour = $urandom_range(0, 3);
    root    = $urandom_range(0, 11);
    mode    = $urandom_range(0, 5);
    pc_a    = $urandom_range(0, 11);
    pc_b    = $urandom_range(0, 11);
    degs    = scale_degrees(mode);
    for (int i = 0; i < size; i++) begin
      case (flavour)
        0: p = PITCH_W'($urandom_range(0, 127));
        3: p = pitch_of_class($urandom_range(0, 1) ? pc_a : pc_b);
        default: begin
          if ($urandom_range(0, 7) == 0) pc = $urandom_range(0, 11);
          else pc = (root + degs[4*$urandom_range(0, 6) +: 4]) % 12;
          p = pitch_of_class(pc);
        end
      endcase
      send_note(p, i == size - 1);
    end
  endtask

  // Pauses the sender until every predicted result has been taken.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // One-note sets at both ends of the pitch range and at pitches 11 and 6; a lone note
  // ties many templates, so the first root and mode holding it must win.
  task automatic test_single_notes();
    send_note(7'd0, 1'b1);
    send_note(7'd127, 1'b1);
    send_note(7'd11, 1'b1);
    send_note(7'd6, 1'b1);
  endtask

  // Every class once, a set over alternating pitch bits, and a tritone pair.
  task automatic test_class_sweep();
    for (int pc = 0; pc < 12; pc++) send_note(PITCH_W'(pc), pc == 11);
    send_note(7'd127, 1'b0);
    send_note(7'd85, 1'b0);
    send_note(7'd42, 1'b0);
    send_note(7'd0, 1'b1);
    send_note(7'd6, 1'b0);
    send_note(7'd0, 1'b0);
    send_note(7'd6, 1'b0);
    send_note(7'd66, 1'b1);
  endtask

  // One long set, which drives the bin, in-scale and tension totals well above the
  // range that short sets reach.
  task automatic test_long_set();
    send_random_set(300);
  endtask

  task automatic test_random_sets(input int unsigned note_budget);
    int unsigned start;
    int unsigned size;
    start = notes_sent;
    while (notes_sent - start < note_budget) begin
      if ($urandom_range(0, 19) == 0) size = $urandom_range(40, 250);
      else size = $urandom_range(1, 24);
      send_random_set(size);
    end
  endtask

  // The receiver holds off for a long stretch while short sets keep coming, so the set
  // queue fills and the input stalls; afterwards the sender waits for everything.
  task automatic test_receiver_holdoff();
    wait_all_results();
    holdoff_cycles = HOLDOFF_LEN;
    for (int s = 0; s < 12; s++) send_random_set(2);
    wait_all_results();
  endtask

  // Back-to-back transactions on both channels with no idling at all.
  task automatic test_steady_stream();
    idle_enable = 1'b0;
    test_random_sets(120);
  endtask

  // Receiver: random short stalls, with a long hold-off when one is requested.
  initial begin : receiver
    int unsigned c;
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles != 0) begin
        out_ready_i <= 1'b0;
        for (c = 0; c < holdoff_cycles; c++) @(posedge clk_i);
        holdoff_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    key_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_keys.size() == 0) begin
        report_mismatch("unexpected result, note_count", note_count_o, 0);
      end else begin
        want = pending_keys.pop_front();
        check_field("key_root", key_root_o, want.root);
        check_field("best_mode", best_mode_o, want.mode);
        check_field("in_scale_count", in_scale_count_o, want.in_scale);
        check_field("note_count", note_count_o, want.notes);
        check_field("scale_score", scale_score_o, want.scale_score);
        check_field("tension_sum", tension_sum_o, want.tension_sum);
        check_field("tension_score", tension_score_o, want.tension_score);
        check_field("distinct_classes", distinct_classes_o, want.distinct);
        keys_checked++;
      end
    end
  end

  // Ends the run if no transaction happens on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    pitch_i        = '0;
    last_i         = 1'b0;
    idle_enable    = 1'b1;
    holdoff_cycles = 0;
    error_count    = 0;
    notes_sent     = 0;
    sets_closed    = 0;
    keys_checked   = 0;
    notes_held     = 0;
    foreach (class_counts[i]) class_counts[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_notes();
    test_class_sweep();
    test_long_set();
    test_random_sets(1050);
    test_receiver_holdoff();
    test_steady_stream();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d notes in %0d sets, %0d results checked, %0d mismatches.",
             notes_sent, sets_closed, keys_checked, error_count);
    $display("Sets ranged from single notes to a few hundred, with a long output hold-off.");
    if (error_count == 0 && pending_keys.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
